// File: hw/rtl/bpq_pkg.sv
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared types, codes and defaults of the bounded priority queue.
// ----------------------------------------------------------------------------
package bpq_pkg;

  // default number of entries
  localparam int CAPACITY_DEF = 128;

  // field widths
  localparam int PRIO_W = 8;
  localparam int TAG_W  = 32;
  localparam int OCC_W  = 8;
  localparam int CFG_W  = 8;
  localparam int IDX_W  = 2;

  // threshold reset values
  localparam logic [CFG_W-1:0] CRITICAL_RST = 8'd15;
  localparam logic [CFG_W-1:0] SEVERE_RST   = 8'd10;
  localparam logic [CFG_W-1:0] MODERATE_RST = 8'd5;

  // register indexes
  localparam logic [IDX_W-1:0] REG_CRITICAL = 2'd0;
  localparam logic [IDX_W-1:0] REG_SEVERE   = 2'd1;
  localparam logic [IDX_W-1:0] REG_MODERATE = 2'd2;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_EXTRACTED = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    LVL_MILD     = 2'd0,
    LVL_MODERATE = 2'd1,
    LVL_SEVERE   = 2'd2,
    LVL_CRITICAL = 2'd3
  } level_t;

  // one stored entry
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   ext;
    entry_t ent;
  } cmd_t;

  // level thresholds
  typedef struct packed {
    logic [CFG_W-1:0] critical;
    logic [CFG_W-1:0] severe;
    logic [CFG_W-1:0] moderate;
  } cfg_t;

endpackage

// File: hw/rtl/bpq_cell.sv
// ----------------------------------------------------------------------------
// bpq_cell
// One slot of the sorted entry chain; shifts toward the tail on insert and
// toward the head on extract.
// ----------------------------------------------------------------------------
module bpq_cell import bpq_pkg::*; (
  input  logic   clk,
  input  cmd_t   cmd,
  input  logic   valid,
  input  logic   prev_keep,
  input  entry_t prev_ent,
  input  entry_t next_ent,
  output entry_t ent,
  output logic   keep
);

  entry_t ent_next;

  // slot holds an entry that stays ahead of the new one (ties stay ahead)
  assign keep = valid && (ent.prio >= cmd.ent.prio);

  // pick hold, new entry or a neighbor's entry
  always_comb begin
    ent_next = ent;
    if (cmd.ins) begin
      if (!keep) begin
        ent_next = prev_keep ? cmd.ent : prev_ent;
      end
    end else if (cmd.ext) begin
      ent_next = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

// File: hw/rtl/bpq_level.sv
// ----------------------------------------------------------------------------
// bpq_level
// Classifies a priority against the three thresholds, critical tested first.
// ----------------------------------------------------------------------------
module bpq_level import bpq_pkg::*; (
  input  cfg_t              cfg,
  input  logic [PRIO_W-1:0] prio,
  output level_t            level
);

  // first threshold met decides
  always_comb begin
    if (prio >= cfg.critical) begin
      level = LVL_CRITICAL;
    end else if (prio >= cfg.severe) begin
      level = LVL_SEVERE;
    end else if (prio >= cfg.moderate) begin
      level = LVL_MODERATE;
    end else begin
      level = LVL_MILD;
    end
  end

endmodule

// File: hw/rtl/bounded_priority_queue.sv
// ----------------------------------------------------------------------------
// bounded_priority_queue
// Bounded max-priority queue built as a sorted chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries opcode, priority_req and tag.
//   An insert places the entry behind all entries of equal or higher
//   priority; an extract returns the head, so ties leave oldest first.
//   Each item gives exactly one result on the output channel (out_valid/
//   out_ready): status, out_priority, out_tag, level and occupancy.
//   The result sits in the output register the cycle after the item is
//   accepted. One item per cycle is sustained while the receiver keeps
//   up; every cell compares its entry with the broadcast item and takes the
//   new entry or a neighbor's entry in the same cycle, so there is no search
//   loop. When the receiver stalls, the output register holds its result and
//   in_ready drops until it is taken.
//   Thresholds are written through cfg_we/cfg_index/cfg_data; the user must
//   write them only while idle, the block does not enforce it. Index 3 is
//   ignored. Reset empties the queue at once (no clearing pass) and
//   restores the default thresholds 15, 10 and 5.
// ----------------------------------------------------------------------------
module bounded_priority_queue import bpq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  input  logic [PRIO_W-1:0] priority_req,
  input  logic [TAG_W-1:0]  tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [PRIO_W-1:0] out_priority,
  output logic [TAG_W-1:0]  out_tag,
  output logic [1:0]        level,
  output logic [OCC_W-1:0]  occupancy,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  cfg_t             cfg;
  cmd_t             cmd;
  logic             in_fire;
  logic             is_ins;
  logic             full;
  logic             empty;

  entry_t           ents  [CAPACITY];
  logic             keeps [CAPACITY];
  logic             cell_valid [CAPACITY];

  status_t          res_status;
  entry_t           res_ent;
  level_t           res_level_raw;
  level_t           res_level;

  // handshake: the output register frees up as its item leaves
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_ins   = (op_t'(opcode) == OP_INSERT);
  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);

  // command broadcast to the chain
  assign cmd.ins      = in_fire && is_ins && !full;
  assign cmd.ext      = in_fire && !is_ins && !empty;
  assign cmd.ent.prio = priority_req;
  assign cmd.ent.tag  = tag;

  // chain of cells, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_valid[i] = (CNT_W'(i) < count);
    if (i == 0) begin : g_head
      bpq_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .valid     (cell_valid[i]),
        .prev_keep (1'b1),
        .prev_ent  (cmd.ent),
        .next_ent  (ents[i+1]),
        .ent       (ents[i]),
        .keep      (keeps[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      bpq_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .valid     (cell_valid[i]),
        .prev_keep (keeps[i-1]),
        .prev_ent  (ents[i-1]),
        .next_ent  (ents[i]),
        .ent       (ents[i]),
        .keep      (keeps[i])
      );
    end else begin : g_mid
      bpq_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .valid     (cell_valid[i]),
        .prev_keep (keeps[i-1]),
        .prev_ent  (ents[i-1]),
        .next_ent  (ents[i+1]),
        .ent       (ents[i]),
        .keep      (keeps[i])
      );
    end
  end

  // result of the accepted item
  always_comb begin
    res_ent    = '0;
    count_next = count;
    if (is_ins) begin
      if (full) begin
        res_status = ST_FULL;
      end else begin
        res_status = ST_INSERTED;
        res_ent    = cmd.ent;
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        res_status = ST_EMPTY;
      end else begin
        res_status = ST_EXTRACTED;
        res_ent    = ents[0];
        count_next = count - 1'b1;
      end
    end
  end

  bpq_level u_level (
    .cfg   (cfg),
    .prio  (res_ent.prio),
    .level (res_level_raw)
  );

  // no level for a refused item
  assign res_level = (res_status == ST_FULL || res_status == ST_EMPTY) ? LVL_MILD
                                                                         : res_level_raw;

  // occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_fire) begin
      count <= count_next;
    end
  end

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.critical <= CRITICAL_RST;
      cfg.severe   <= SEVERE_RST;
      cfg.moderate <= MODERATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CRITICAL: cfg.critical <= cfg_data;
        REG_SEVERE:   cfg.severe   <= cfg_data;
        REG_MODERATE: cfg.moderate <= cfg_data;
        default:      ;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status       <= res_status;
      out_priority <= res_ent.prio;
      out_tag      <= res_ent.tag;
      level        <= res_level;
      occupancy    <= OCC_W'(count_next);
    end
  end

  // count stays within the chain
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("entry count exceeds capacity");

  // head of the chain is never below its successor
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (ents[0].prio >= ents[1].prio))
    else $error("chain head out of order");

  // a successful insert grows the queue by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> (count == $past(count) + 1'b1))
    else $error("insert did not add an entry");

  // a refused item carries no entry
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL || status == ST_EMPTY))
      |-> (out_priority == '0 && out_tag == '0 && level == LVL_MILD))
    else $error("refused item carries entry data");

  // extract never reported while the queue was empty
  a_no_ghost_extract: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !is_ins && empty) |=> (status == ST_EMPTY && occupancy == '0))
    else $error("extract from empty queue misreported");

endmodule
